FILE: rtl/ntcat_pkg.sv
// shared widths, constants, register codes and request structs for the
// ntc averaging and temperature block; no dependencies
package ntcat_pkg;

  localparam int unsigned SAMPLE_COUNT_DEF = 10;
  localparam int unsigned CODE_MAX_DEF     = 4095;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TEMP_W   = 18;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned IDX_W    = 6;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METHOD  = 3'd0,
    CFG_BETA    = 3'd1,
    CFG_SERIES  = 3'd2,
    CFG_NOMINAL = 3'd3,
    CFG_SLOPE   = 3'd4,
    CFG_OFFSET  = 3'd5
  } cfg_reg_e;

  localparam logic [1:0] METHOD_BETA  = 2'd1;
  localparam logic [1:0] METHOD_TABLE = 2'd2;

  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd27315;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd99999;

  // serial divider
  localparam int unsigned DIV_NUM_W = 72;
  localparam int unsigned DIV_DEN_W = 57;
  localparam int unsigned DIV_CNT_W = 7;

  // serial log2, result is exponent and 32 fraction bits
  localparam int unsigned LOG_IN_W   = 20;
  localparam int unsigned LOG_EXP_W  = 5;
  localparam int unsigned LOG_FRAC_W = 32;
  localparam int unsigned LOG_W      = LOG_EXP_W + LOG_FRAC_W;

  localparam logic [23:0] LN2_Q24         = 24'd11629080;
  localparam logic [14:0] T0_CENTI        = 15'd29815;
  localparam logic [22:0] BETA_P_K        = 23'd5963000;  // 200 * T0_CENTI
  localparam logic [11:0] CLAMP_INV_RATIO = 12'd3299;

  localparam logic [11:0] TAB_P0   = 12'd3500;
  localparam logic [11:0] TAB_P1   = 12'd2400;
  localparam logic [11:0] TAB_P2   = 12'd1550;
  localparam logic [11:0] TAB_P3   = 12'd950;
  localparam logic [12:0] TAB_STEP = 13'd2500;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                start;
    logic [LOG_IN_W-1:0] operand;
  } log_req_t;

endpackage

FILE: rtl/ntcat_if.sv
// valid/ready channel interfaces for samples, results and register writes
// depends on ntcat_pkg
interface ntcat_sample_if import ntcat_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface ntcat_result_if import ntcat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temp_centi;
  logic [SAMPLE_W-1:0]      average_code;
  logic                     degenerate;
  modport source (output valid, output temp_centi, output average_code,
                  output degenerate, input ready);
  modport sink (input valid, input temp_centi, input average_code,
                input degenerate, output ready);
endinterface

interface ntcat_cfg_if import ntcat_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/ntcat_div.sv
// restoring divider, one quotient bit per cycle
// numerator comes left aligned, only the top iters bits are processed; uses ntcat_pkg
module ntcat_div import ntcat_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : DIV_DEN_W'(rem_sh);
      quo_d = {quo_q[DIV_NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/ntcat_log2.sv
// log2 in q32: bit-serial normalization, then 32 squaring steps of the mantissa
// one fraction bit per cycle; uses ntcat_pkg
module ntcat_log2 import ntcat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  log_req_t         req_i,
  output logic             done_o,
  output logic [LOG_W-1:0] result_o
);

  localparam logic [1:0] LG_IDLE = 2'd0;
  localparam logic [1:0] LG_NORM = 2'd1;
  localparam logic [1:0] LG_SQR  = 2'd2;
  localparam int unsigned MANT_W = LOG_FRAC_W - 1;

  logic [1:0]            phase_q, phase_d;
  logic                  done_q, done_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [LOG_EXP_W-1:0]  exp_q, exp_d;
  logic [LOG_IN_W-1:0]   m_q, m_d;
  logic [MANT_W-1:0]     mant_q, mant_d;
  logic [LOG_FRAC_W-1:0] frac_q, frac_d;
  logic [2*MANT_W-1:0]   sq;
  logic [LOG_FRAC_W-1:0] sq_hi;

  always_comb begin
    sq      = mant_q * mant_q;
    sq_hi   = sq[2*MANT_W-1:MANT_W-1];
    phase_d = phase_q;
    cnt_d   = cnt_q;
    exp_d   = exp_q;
    m_d     = m_q;
    mant_d  = mant_q;
    frac_d  = frac_q;
    done_d  = 1'b0;
    case (phase_q)
      LG_IDLE: begin
        if (req_i.start) begin
          m_d     = (req_i.operand == '0) ? LOG_IN_W'(1) : req_i.operand;
          exp_d   = LOG_EXP_W'(LOG_IN_W - 1);
          phase_d = LG_NORM;
        end
      end
      LG_NORM: begin
        if (m_q[LOG_IN_W-1]) begin
          mant_d  = {m_q, {(MANT_W - LOG_IN_W){1'b0}}};
          cnt_d   = 5'd31;
          phase_d = LG_SQR;
        end else begin
          m_d   = {m_q[LOG_IN_W-2:0], 1'b0};
          exp_d = exp_q - 1'b1;
        end
      end
      LG_SQR: begin
        mant_d = sq_hi[LOG_FRAC_W-1] ? sq_hi[LOG_FRAC_W-1:1] : sq_hi[MANT_W-1:0];
        frac_d = {frac_q[LOG_FRAC_W-2:0], sq_hi[LOG_FRAC_W-1]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == 5'd0) begin
          done_d  = 1'b1;
          phase_d = LG_IDLE;
        end
      end
      default: phase_d = LG_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= LG_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    m_q    <= m_d;
    mant_q <= mant_d;
    frac_q <= frac_d;
  end

  assign done_o   = done_q;
  assign result_o = {exp_q, frac_q};

endmodule

FILE: rtl/ntc_average_to_temperature.sv
// top level: sample accumulator, conversion sequencer and result register
// uses ntcat_pkg, ntcat_if, ntcat_div and ntcat_log2

// Samples are summed in groups of SAMPLE_COUNT and one result follows each group.
// Samples are taken every cycle; only the sample that closes a group waits while
// the previous group is still converting or its result still waits to enter the
// output register. After the closing sample the divider forms the mean; the
// linear law then takes one more divide, the table one divide between its points,
// and the beta equation three or four serial log2 runs (up to 19 normalizing
// shifts plus 32 squaring steps each), two shift-add multiplies and a restoring
// divide. A finished result sits in an output register so accumulation of the
// next group goes on while it waits for its transfer.
module ntc_average_to_temperature import ntcat_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int unsigned CODE_MAX     = CODE_MAX_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ntcat_sample_if.sink   smp_i,
  ntcat_result_if.source res_o,
  ntcat_cfg_if.sink      cfg_i
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_AVG      = 4'd1;
  localparam logic [3:0] ST_DISPATCH = 4'd2;
  localparam logic [3:0] ST_LIN      = 4'd3;
  localparam logic [3:0] ST_TAB      = 4'd4;
  localparam logic [3:0] ST_LOGSTART = 4'd5;
  localparam logic [3:0] ST_LOGWAIT  = 4'd6;
  localparam logic [3:0] ST_MAG      = 4'd7;
  localparam logic [3:0] ST_LN2      = 4'd8;
  localparam logic [3:0] ST_T0SET    = 4'd9;
  localparam logic [3:0] ST_T0       = 4'd10;
  localparam logic [3:0] ST_DEN      = 4'd11;
  localparam logic [3:0] ST_BDIV     = 4'd12;
  localparam logic [3:0] ST_OUT      = 4'd13;

  localparam int unsigned LG_W    = 40;
  localparam int unsigned MUL_W   = 64;
  localparam int unsigned MUL_K_W = 24;
  localparam int unsigned DEN_S_W = 58;
  localparam int unsigned LIN_W   = 29;
  localparam int unsigned TAB_W   = 22;
  localparam int unsigned WIDE_W  = 32;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);
  localparam logic [15:0] CODE_HALF     = 16'(CODE_MAX / 2);
  localparam logic [TEMP_W-1:0] BQ_LIMIT = 18'd254628;

  // configuration registers
  logic [1:0]        method_q;
  logic [15:0]       beta_q;
  logic [19:0]       series_q;
  logic [19:0]       nominal_q;
  logic [7:0]        slope_q;
  logic signed [7:0] offset_q;

  // accumulator
  logic [SUM_W-1:0] sum_q, sum_nx;
  logic [IDX_W-1:0] idx_q;
  logic             smp_fire, grp_done, cfg_fire;

  // sequencer
  logic [3:0]                state_q, state_d;
  logic [1:0]                step_q, step_d;
  logic [4:0]                mul_cnt_q, mul_cnt_d;
  logic [SAMPLE_W-1:0]       avg_q, avg_d;
  logic signed [LG_W-1:0]    lg_q, lg_d;
  logic                      neg_q, neg_d;
  logic [MUL_W-1:0]          mul_sh_q, mul_sh_d;
  logic [MUL_K_W-1:0]        mul_k_q, mul_k_d;
  logic [MUL_W-1:0]          acc_q, acc_d;
  logic [12:0]               base_q, base_d;
  logic signed [TEMP_W-1:0]  t_q, t_d;
  logic                      degen_q, degen_d;
  logic                      res_load;

  // output register
  logic                     res_valid_q;
  logic signed [TEMP_W-1:0] res_temp_q;
  logic [SAMPLE_W-1:0]      res_avg_q;
  logic                     res_degen_q;

  // shared units
  div_req_t             div_req;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  log_req_t             log_req;
  logic                 log_done;
  logic [LOG_W-1:0]     log_res;

  // datapath helpers
  logic [15:0]                beta_eff;
  logic [19:0]                series_eff, nominal_eff;
  logic                       low_clamp;
  logic [LOG_IN_W-1:0]        log_op;
  logic                       log_neg;
  logic [LG_W-1:0]            lg_abs;
  logic [16:0]                slope330;
  logic [LIN_W-1:0]           lin_num;
  logic signed [15:0]         off100;
  logic signed [27:0]         lin_t;
  logic [11:0]                tab_hi, tab_span, tab_diff;
  logic [12:0]                tab_base;
  logic [TAB_W-1:0]           tab_num;
  logic [22:0]                beta100;
  logic signed [DEN_S_W-1:0]  den_a, den_b, den_s;
  logic [38:0]                beta_p;
  logic [TEMP_W:0]            bq_half;

  function automatic logic signed [TEMP_W-1:0] clamp_temp(input logic signed [27:0] v);
    if (v < 28'(TEMP_MIN)) begin
      return TEMP_MIN;
    end else if (v > 28'(TEMP_MAX)) begin
      return TEMP_MAX;
    end
    return TEMP_W'(v);
  endfunction

  ntcat_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  ntcat_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (log_req),
    .done_o   (log_done),
    .result_o (log_res)
  );

  // accumulator and configuration
  assign smp_i.ready = (state_q == ST_IDLE) || (idx_q != IDX_LAST);
  assign smp_fire    = smp_i.valid && smp_i.ready;
  assign grp_done    = smp_fire && (idx_q == IDX_LAST);
  assign sum_nx      = sum_q + SUM_W'(smp_i.sample);
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
    end else if (smp_fire) begin
      if (grp_done) begin
        sum_q <= '0;
        idx_q <= '0;
      end else begin
        sum_q <= sum_nx;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q  <= METHOD_BETA;
      beta_q    <= 16'd3950;
      series_q  <= 20'd10000;
      nominal_q <= 20'd10000;
      slope_q   <= 8'd20;
      offset_q  <= 8'sd15;
    end else if (cfg_fire) begin
      case (cfg_i.index)
        CFG_METHOD:  method_q  <= cfg_i.data[1:0];
        CFG_BETA:    beta_q    <= cfg_i.data[15:0];
        CFG_SERIES:  series_q  <= cfg_i.data;
        CFG_NOMINAL: nominal_q <= cfg_i.data;
        CFG_SLOPE:   slope_q   <= cfg_i.data[7:0];
        CFG_OFFSET:  offset_q  <= $signed(cfg_i.data[7:0]);
        default: ;
      endcase
    end
  end

  // operand preparation
  always_comb begin
    beta_eff    = (beta_q == '0) ? 16'd1 : beta_q;
    series_eff  = (series_q == '0) ? 20'd1 : series_q;
    nominal_eff = (nominal_q == '0) ? 20'd1 : nominal_q;
    low_clamp   = (WIDE_W'(avg_q) * WIDE_W'(3300)) <= WIDE_W'(CODE_MAX);

    case (step_q)
      2'd0: begin
        log_op  = low_clamp ? LOG_IN_W'(CLAMP_INV_RATIO) : LOG_IN_W'(avg_q);
        log_neg = low_clamp;
      end
      2'd1: begin
        log_op  = LOG_IN_W'(CODE_MAX) - LOG_IN_W'(avg_q);
        log_neg = 1'b1;
      end
      2'd2: begin
        log_op  = series_eff;
        log_neg = 1'b0;
      end
      default: begin
        log_op  = nominal_eff;
        log_neg = 1'b1;
      end
    endcase

    lg_abs = lg_q[LG_W-1] ? LG_W'(-lg_q) : LG_W'(lg_q);

    slope330 = 17'(slope_q) * 17'd330;
    lin_num  = LIN_W'(avg_q) * LIN_W'(slope330) + LIN_W'(CODE_HALF);
    off100   = offset_q * 16'sd100;
    lin_t    = $signed({6'b0, div_quo[21:0]}) + 28'(off100);

    if (avg_q >= TAB_P1) begin
      tab_hi   = TAB_P0;
      tab_span = TAB_P0 - TAB_P1;
      tab_base = '0;
    end else if (avg_q >= TAB_P2) begin
      tab_hi   = TAB_P1;
      tab_span = TAB_P1 - TAB_P2;
      tab_base = TAB_STEP;
    end else begin
      tab_hi   = TAB_P2;
      tab_span = TAB_P2 - TAB_P3;
      tab_base = 13'(2 * TAB_STEP);
    end
    tab_diff = tab_hi - avg_q;
    tab_num  = TAB_W'(tab_diff) * TAB_W'(TAB_STEP) + TAB_W'(tab_span >> 1);

    // denominator is 100*beta*2^32 +/- T0 * ln(ratio)
    beta100 = 23'(beta_eff) * 23'd100;
    den_a   = $signed({3'b0, beta100, 32'b0});
    den_b   = $signed({4'b0, acc_q[53:0]});
    den_s   = neg_q ? (den_a - den_b) : (den_a + den_b);
    beta_p  = 39'(beta_eff) * 39'(BETA_P_K);
    bq_half = ({1'b0, div_quo[TEMP_W-1:0]} + 1'b1) >> 1;
  end

  // conversion sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    mul_cnt_d = mul_cnt_q;
    avg_d     = avg_q;
    lg_d      = lg_q;
    neg_d     = neg_q;
    mul_sh_d  = mul_sh_q;
    mul_k_d   = mul_k_q;
    acc_d     = acc_q;
    base_d    = base_q;
    t_d       = t_q;
    degen_d   = degen_q;
    div_req   = '0;
    log_req   = '0;
    res_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (grp_done) begin
          div_req.start = 1'b1;
          div_req.iters = DIV_CNT_W'(SUM_W);
          div_req.num   = {sum_nx, {(DIV_NUM_W - SUM_W){1'b0}}};
          div_req.den   = DIV_DEN_W'(SAMPLE_COUNT);
          state_d       = ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          avg_d   = div_quo[SAMPLE_W-1:0];
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        degen_d = 1'b0;
        if (method_q == METHOD_BETA) begin
          if (WIDE_W'(avg_q) >= WIDE_W'(CODE_MAX)) begin
            t_d     = TEMP_MIN;
            degen_d = 1'b1;
            state_d = ST_OUT;
          end else begin
            lg_d    = '0;
            step_d  = 2'd0;
            state_d = ST_LOGSTART;
          end
        end else if (method_q == METHOD_TABLE) begin
          if (avg_q >= TAB_P0) begin
            t_d     = '0;
            state_d = ST_OUT;
          end else if (avg_q <= TAB_P3) begin
            t_d     = TEMP_W'(3 * TAB_STEP);
            state_d = ST_OUT;
          end else begin
            div_req.start = 1'b1;
            div_req.iters = DIV_CNT_W'(TAB_W);
            div_req.num   = {tab_num, {(DIV_NUM_W - TAB_W){1'b0}}};
            div_req.den   = DIV_DEN_W'(tab_span);
            base_d        = tab_base;
            state_d       = ST_TAB;
          end
        end else begin
          div_req.start = 1'b1;
          div_req.iters = DIV_CNT_W'(LIN_W);
          div_req.num   = {lin_num, {(DIV_NUM_W - LIN_W){1'b0}}};
          div_req.den   = DIV_DEN_W'(CODE_MAX);
          state_d       = ST_LIN;
        end
      end
      ST_LIN: begin
        if (div_done) begin
          t_d     = clamp_temp(lin_t);
          state_d = ST_OUT;
        end
      end
      ST_TAB: begin
        if (div_done) begin
          t_d     = $signed(TEMP_W'(base_q + div_quo[12:0]));
          state_d = ST_OUT;
        end
      end
      ST_LOGSTART: begin
        log_req.start   = 1'b1;
        log_req.operand = log_op;
        state_d         = ST_LOGWAIT;
      end
      ST_LOGWAIT: begin
        if (log_done) begin
          lg_d = log_neg ? (lg_q - $signed(LG_W'(log_res)))
                         : (lg_q + $signed(LG_W'(log_res)));
          if (step_q == 2'd3) begin
            state_d = ST_MAG;
          end else begin
            // the clamped case uses one constant log in place of the ratio
            step_d  = (step_q == 2'd0 && low_clamp) ? 2'd2 : step_q + 1'b1;
            state_d = ST_LOGSTART;
          end
        end
      end
      ST_MAG: begin
        neg_d     = lg_q[LG_W-1];
        mul_sh_d  = MUL_W'(lg_abs);
        mul_k_d   = LN2_Q24;
        acc_d     = '0;
        mul_cnt_d = 5'(MUL_K_W);
        state_d   = ST_LN2;
      end
      ST_LN2, ST_T0: begin
        acc_d     = acc_q + (mul_k_q[0] ? mul_sh_q : '0);
        mul_sh_d  = mul_sh_q << 1;
        mul_k_d   = mul_k_q >> 1;
        mul_cnt_d = mul_cnt_q - 1'b1;
        if (mul_cnt_q == 5'd1) begin
          state_d = (state_q == ST_LN2) ? ST_T0SET : ST_DEN;
        end
      end
      ST_T0SET: begin
        mul_sh_d  = acc_q >> MUL_K_W;
        mul_k_d   = MUL_K_W'(T0_CENTI);
        acc_d     = '0;
        mul_cnt_d = 5'(MUL_K_W);
        state_d   = ST_T0;
      end
      ST_DEN: begin
        if (den_s[DEN_S_W-1] || den_s == '0) begin
          t_d     = TEMP_MIN;
          state_d = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.iters = DIV_CNT_W'(DIV_NUM_W);
          div_req.num   = {1'b0, beta_p, 32'b0};
          div_req.den   = den_s[DIV_DEN_W-1:0];
          state_d       = ST_BDIV;
        end
      end
      ST_BDIV: begin
        if (div_done) begin
          if ((|div_quo[DIV_NUM_W-1:TEMP_W]) || div_quo[TEMP_W-1:0] >= BQ_LIMIT) begin
            t_d = TEMP_MAX;
          end else begin
            t_d = $signed(bq_half[TEMP_W-1:0]) + TEMP_MIN;
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mul_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      mul_cnt_q <= mul_cnt_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q    <= avg_d;
    lg_q     <= lg_d;
    neg_q    <= neg_d;
    mul_sh_q <= mul_sh_d;
    mul_k_q  <= mul_k_d;
    acc_q    <= acc_d;
    base_q   <= base_d;
    t_q      <= t_d;
    degen_q  <= degen_d;
    if (res_load) begin
      res_temp_q  <= t_q;
      res_avg_q   <= avg_q;
      res_degen_q <= degen_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.temp_centi   = res_temp_q;
  assign res_o.average_code = res_avg_q;
  assign res_o.degenerate   = res_degen_q;

`ifndef SYNTHESIS
  a_degen_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.degenerate |-> res_o.temp_centi == TEMP_MIN)
    else $error("degenerate result without minimum temperature");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IDX_W'(SAMPLE_COUNT))
    else $error("sample index beyond group size");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_AVG || state_q == ST_LIN || state_q == ST_TAB ||
                  state_q == ST_BDIV))
    else $error("divider finished outside a divide wait");

  a_log_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> state_q == ST_LOGWAIT)
    else $error("log2 finished outside log wait");
`endif

endmodule

FILE: verif/ntcat_checker.sv
// result predictor and scoreboard for ntc_average_to_temperature
// watches the sample, result and register channels; depends on ntcat_pkg, ntcat_if
module ntcat_checker import ntcat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic smp_valid_i,
  input  logic smp_ready_i,
  input  logic [SAMPLE_W-1:0] smp_sample_i,
  input  logic res_valid_i,
  input  logic res_ready_i,
  input  logic signed [TEMP_W-1:0] res_temp_i,
  input  logic [SAMPLE_W-1:0] res_avg_i,
  input  logic res_degen_i,
  input  logic cfg_valid_i,
  input  logic cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int   pending_o,
  output int   errors_o,
  output int   results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GROUP = SAMPLE_COUNT_DEF;
  localparam int unsigned FULL  = CODE_MAX_DEF;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [SAMPLE_W-1:0]      avg;
    logic                     degen;
  } reading_t;

  reading_t readings_q[$];

  logic [1:0]  conv_method;
  logic [15:0] beta_k;
  logic [19:0] series_r, nominal_r;
  logic [7:0]  slope;
  logic signed [7:0] offset;
  logic [17:0] acc_sum;
  logic [5:0]  acc_cnt;

  function automatic longint sat_temp(longint t);
    if (t < -27315) return -27315;
    if (t > 99999) return 99999;
    return t;
  endfunction

  function automatic longint log2_fix(longint unsigned n);
    int e;
    longint unsigned m, frac;
    e = 31;
    frac = 0;
    if (n == 0) n = 1;
    while (((n >> e) & 1) == 0) e--;
    m = (n << 30) >> e;
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 64'd1 << (31 - i);
      end
    end
    return longint'((64'(e) << 32) | frac);
  endfunction

  function automatic longint beta_law(int unsigned code, output logic degen);
    longint unsigned b, rs, rn, mag, p, q;
    longint lg, lq, den;
    logic [127:0] num;
    logic [127:0] rem;
    logic sat;
    b  = beta_k ? beta_k : 1;
    rs = series_r ? series_r : 1;
    rn = nominal_r ? nominal_r : 1;
    degen = 1'b0;
    if (code >= FULL) begin
      degen = 1'b1;
      return -27315;
    end
    if (longint'(code) * 3300 <= FULL) lg = -log2_fix(longint'(CLAMP_INV_RATIO));
    else lg = log2_fix(code) - log2_fix(FULL - code);
    lg += log2_fix(rs) - log2_fix(rn);
    mag = lg < 0 ? -lg : lg;
    mag = (mag * LN2_Q24) >> 24;
    lq = lg < 0 ? -longint'(mag) : longint'(mag);
    den = longint'(T0_CENTI) * lq + longint'(100 * b) * 64'sd4294967296;
    if (den <= 0) return -27315;
    p = 200 * b * T0_CENTI;
    num = {64'd0, p} << 32;
    rem = 0;
    q = 0;
    sat = 1'b0;
    for (int i = 127; i >= 0; i--) begin
      rem = (rem << 1) | num[i];
      if (rem >= den) begin
        rem -= den;
        if (i >= 40) sat = 1'b1;
        else q |= 64'd1 << i;
      end
    end
    if (sat) q = 64'd1 << 40;
    if (q >= 2 * (99999 + 27315)) return 99999;
    return sat_temp(longint'((q + 1) >> 1) - 27315);
  endfunction

  function automatic longint table_law(int unsigned code);
    int unsigned pts[4], k, span, n;
    pts = '{3500, 2400, 1550, 950};
    if (code >= pts[0]) return 0;
    if (code <= pts[3]) return 7500;
    for (k = 0; k < 3; k++)
      if (code <= pts[k] && code >= pts[k+1]) break;
    span = pts[k] - pts[k+1];
    n = 2500 * (pts[k] - code);
    return k * 2500 + (n + span / 2) / span;
  endfunction

  function automatic reading_t convert(int unsigned code);
    reading_t r;
    longint t;
    logic dg;
    longint unsigned prod;
    dg = 1'b0;
    if (conv_method == METHOD_BETA) t = beta_law(code, dg);
    else if (conv_method == METHOD_TABLE) t = table_law(code);
    else begin
      prod = longint'(code) * 330 * slope;
      t = sat_temp(longint'((prod + FULL / 2) / FULL) + longint'(offset) * 100);
    end
    r.temp = t[TEMP_W-1:0];
    r.avg = code[SAMPLE_W-1:0];
    r.degen = dg;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    results_o = 0;
  end
  assign pending_o = readings_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t w;
    logic [17:0] s;
    if (!rst_ni) begin
      conv_method <= METHOD_BETA;
      beta_k <= 16'd3950;
      series_r <= 20'd10000;
      nominal_r <= 20'd10000;
      slope <= 8'd20;
      offset <= 8'sd15;
      acc_sum <= '0;
      acc_cnt <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_METHOD:  conv_method <= cfg_data_i[1:0];
          CFG_BETA:    beta_k <= cfg_data_i[15:0];
          CFG_SERIES:  series_r <= cfg_data_i;
          CFG_NOMINAL: nominal_r <= cfg_data_i;
          CFG_SLOPE:   slope <= cfg_data_i[7:0];
          CFG_OFFSET:  offset <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (smp_valid_i && smp_ready_i) begin
        s = acc_sum + smp_sample_i;
        if (acc_cnt + 6'd1 >= GROUP) begin
          readings_q.push_back(convert(s / GROUP));
          acc_sum <= '0;
          acc_cnt <= '0;
        end else begin
          acc_sum <= s;
          acc_cnt <= acc_cnt + 6'd1;
        end
      end
      if (res_valid_i && res_ready_i) begin
        results_o++;
        if (readings_q.size() == 0) report("unexpected result", res_temp_i, 0);
        else begin
          w = readings_q.pop_front();
          if (res_temp_i !== w.temp) report("temp_centi", res_temp_i, w.temp);
          if (res_avg_i !== w.avg) report("average_code", res_avg_i, w.avg);
          if (res_degen_i !== w.degen) report("degenerate", res_degen_i, w.degen);
        end
      end
    end
  end
endmodule

FILE: verif/tb_ntc_average_to_temperature.sv
// stimulus and verdict for ntc_average_to_temperature
// depends on ntcat_pkg, ntcat_if, the block and ntcat_checker
module tb_ntc_average_to_temperature;
  import ntcat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int pending, errors, results, cycles;
  int send_idle, recv_idle;
  bit hold_off;

  ntcat_sample_if smp();
  ntcat_result_if res();
  ntcat_cfg_if    cfg();

  ntc_average_to_temperature i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .smp_i(smp), .res_o(res), .cfg_i(cfg)
  );

  ntcat_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .smp_valid_i(smp.valid), .smp_ready_i(smp.ready), .smp_sample_i(smp.sample),
    .res_valid_i(res.valid), .res_ready_i(res.ready), .res_temp_i(res.temp_centi),
    .res_avg_i(res.average_code), .res_degen_i(res.degenerate),
    .cfg_valid_i(cfg.valid), .cfg_ready_i(cfg.ready), .cfg_index_i(cfg.index),
    .cfg_data_i(cfg.data), .pending_o(pending), .errors_o(errors), .results_o(results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    smp.valid = 1'b0;
    smp.sample = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_METHOD;
    cfg.data = '0;
    res.ready = 1'b0;
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(99) >= recv_idle);
  end

  // valid stays high between back to back transfers
  task automatic send(logic [SAMPLE_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.sample <= v;
    do @(posedge clk_i); while (!smp.ready);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // a whole group of one code, so the mean is exact
  task automatic group_of(logic [SAMPLE_W-1:0] v);
    repeat (SAMPLE_COUNT_DEF) send(v);
  endtask

  task automatic random_groups(int n);
    int mode;
    for (int g = 0; g < n; g++) begin
      mode = $urandom_range(3);
      for (int i = 0; i < SAMPLE_COUNT_DEF; i++) begin
        if (mode == 0) send(12'($urandom));
        else if (mode == 1) send(12'($urandom_range(4095, 4080)));
        else if (mode == 2) send(12'($urandom_range(10, 0)));
        else send(12'($urandom_range(3600, 850)));
      end
    end
  endtask

  logic [1:0] meth;

  initial begin
    send_idle = 15;
    recv_idle = 79;
    hold_off = 1'b0;
    cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings (beta), extremes and clamp edges
    group_of(12'd4095);
    group_of(12'd0);
    group_of(12'd1);
    send(12'hAAA); send(12'h555);
    repeat (8) send(12'd2048);
    drain();
    write_reg(CFG_METHOD, 20'(METHOD_TABLE));
    group_of(12'd3500);
    group_of(12'd950);
    group_of(12'd2400);
    group_of(12'd1549);
    drain();
    write_reg(CFG_METHOD, 20'd3);
    write_reg(CFG_SLOPE, 20'd255);
    write_reg(CFG_OFFSET, 20'h80);
    group_of(12'd4095);
    group_of(12'd0);
    drain();
    write_reg(CFG_METHOD, 20'd0);
    write_reg(CFG_OFFSET, 20'h7F);
    group_of(12'd4095);
    drain();

    // random phases over varied settings
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 6) begin
        send_idle = 79;
        recv_idle = 15;
      end else if (ph == 11) begin
        send_idle = 0;
        recv_idle = 0;
      end
      meth = (ph % 4 == 0) ? 2'd0 : (ph % 4 == 3) ? METHOD_TABLE : METHOD_BETA;
      write_reg(CFG_METHOD, 20'(meth));
      case (ph % 5)
        0: begin
          write_reg(CFG_BETA, 20'd0);
          write_reg(CFG_SERIES, 20'd0);
          write_reg(CFG_NOMINAL, 20'hFFFFF);
        end
        1: begin
          write_reg(CFG_BETA, 20'd65535);
          write_reg(CFG_SERIES, 20'd1000000);
          write_reg(CFG_NOMINAL, 20'd1);
        end
        2: begin
          write_reg(CFG_BETA, 20'd1);
          write_reg(CFG_SERIES, 20'd1);
          write_reg(CFG_NOMINAL, 20'd1000000);
        end
        default: begin
          write_reg(CFG_BETA, 20'($urandom_range(65535)));
          write_reg(CFG_SERIES, 20'($urandom));
          write_reg(CFG_NOMINAL, 20'($urandom));
        end
      endcase
      write_reg(CFG_SLOPE, (ph == 2) ? 20'd0 : 20'($urandom_range(255)));
      write_reg(CFG_OFFSET, 20'($urandom_range(255)));
      if (ph == 12) begin
        // long receiver stall while samples keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clk_i);
            hold_off = 1'b0;
          end
          random_groups(8);
        join
      end else begin
        random_groups(9);
      end
      drain();
    end

    $display("covered %0d results over linear, beta and table laws", results);
    $display("register extremes, zero registers and long output stalls exercised");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
